// File: rtl/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg
// Shared types and constants of the fixed-point vector normalizer.
// ----------------------------------------------------------------------------
package vnf_pkg;

    localparam int COMP_W     = 32;
    localparam int LEN_W      = 16;
    localparam int SQRT_STEPS = 16;
    localparam logic [COMP_W-1:0] SAT_MAX = 32'h7FFF_FFFF;

    // control that rides along each pipeline slot
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

// File: rtl/vector_normalize_fixed_unit.sv
// Throughput: one item per cycle while no result waits on the output register;
// a chain of 16 root cells and 32 + FRAC_BITS divider cells, each taking one
// registered step, carries each item from the front stages to the output register.
// The whole chain holds while a result waits on the output register.
// Reset (synchronous, active low) clears all valid bits and r_narrow.
// ----------------------------------------------------------------------------
// vector_normalize_fixed_unit
// Scales a signed 3-component vector to unit length in Q(FRAC_BITS); narrow mode sign-extends the low 16 bits.
// ----------------------------------------------------------------------------
module vector_normalize_fixed_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // in_x[31:0], in_y[63:32], in_z[95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // out_x[31:0], out_y[63:32], out_z[95:64]
);
    import vnf_pkg::*;

    localparam int DW = COMP_W + FRAC_BITS;
    localparam int PW = 3 * COMP_W;

    logic en;
    logic r_narrow;

    // front stages: capture, square, sum
    t_ctl              r_ctl_a, r_ctl_b, r_ctl_c;
    logic [PW-1:0]     r_pay_a, r_pay_b, r_pay_c;
    logic [2:0][COMP_W-1:0] r_sq;
    logic [COMP_W-1:0] r_sum;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow <= 1'b0;
            r_ctl_a  <= '0;
            r_ctl_b  <= '0;
            r_ctl_c  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_narrow <= i_cfg_wdata;
            end
            if (en) begin
                r_ctl_a <= '{valid: s_axis_tvalid, zero: 1'b0};
                r_ctl_b <= r_ctl_a;
                r_ctl_c <= '{valid: r_ctl_b.valid,
                             zero: 1'(r_sq[0] + r_sq[1] + r_sq[2] >> (COMP_W-1))};
            end
        end
        if (en) begin
            r_pay_a <= s_axis_tdata;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= COMP_W'(r_pay_a[k*COMP_W +: COMP_W] * r_pay_a[k*COMP_W +: COMP_W]);
            end
            r_pay_b <= r_pay_a;
            r_sum   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_pay_c <= r_pay_b;
        end
    end

    // square root chain
    t_ctl                  s_ctl  [SQRT_STEPS+1];
    logic [COMP_W-1:0]     s_v    [SQRT_STEPS+1];
    logic [COMP_W-1:0]     s_root [SQRT_STEPS+1];
    logic [PW-1:0]         s_pay  [SQRT_STEPS+1];

    assign s_ctl[0]  = r_ctl_c;
    assign s_v[0]    = r_sum;
    assign s_root[0] = '0;
    assign s_pay[0]  = r_pay_c;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        vnf_sqrt_cell #(.SHIFT(COMP_W - 2 - 2*g), .PW(PW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (s_ctl[g]),
            .i_v    (s_v[g]),
            .i_root (s_root[g]),
            .i_pay  (s_pay[g]),
            .o_ctl  (s_ctl[g+1]),
            .o_v    (s_v[g+1]),
            .o_root (s_root[g+1]),
            .o_pay  (s_pay[g+1])
        );
    end

    // prepare magnitudes and divisor
    t_ctl                  r_ctl_p;
    logic [LEN_W-1:0]      r_len_p;
    logic [2:0][DW-1:0]    r_dq_p;
    logic [2:0]            r_neg_p;
    logic [COMP_W-1:0]     comp [3];
    logic [COMP_W-1:0]     mag  [3];
    logic [LEN_W-1:0]      len_s;

    always_comb begin
        len_s = s_root[SQRT_STEPS][LEN_W-1:0];
        for (int k = 0; k < 3; k++) begin
            comp[k] = s_pay[SQRT_STEPS][k*COMP_W +: COMP_W];
            mag[k]  = comp[k][COMP_W-1] ? (~comp[k] + COMP_W'(1)) : comp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_p <= '0;
        end else if (en) begin
            r_ctl_p <= '{valid: s_ctl[SQRT_STEPS].valid,
                         zero: s_ctl[SQRT_STEPS].zero || (len_s == '0)};
        end
        if (en) begin
            r_len_p <= len_s;
            for (int k = 0; k < 3; k++) begin
                r_dq_p[k]  <= {mag[k], {FRAC_BITS{1'b0}}};
                r_neg_p[k] <= comp[k][COMP_W-1];
            end
        end
    end

    // divider chain
    t_ctl                  d_ctl [DW+1];
    logic [LEN_W-1:0]      d_len [DW+1];
    logic [2:0][LEN_W-1:0] d_rem [DW+1];
    logic [2:0][DW-1:0]    d_dq  [DW+1];
    logic [2:0]            d_neg [DW+1];

    assign d_ctl[0] = r_ctl_p;
    assign d_len[0] = r_len_p;
    assign d_rem[0] = '0;
    assign d_dq[0]  = r_dq_p;
    assign d_neg[0] = r_neg_p;

    for (genvar g = 0; g < DW; g++) begin : g_div
        vnf_div_cell #(.DW(DW), .PW(3)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (d_ctl[g]),
            .i_len  (d_len[g]),
            .i_rem  (d_rem[g]),
            .i_dq   (d_dq[g]),
            .i_pay  (d_neg[g]),
            .o_ctl  (d_ctl[g+1]),
            .o_len  (d_len[g+1]),
            .o_rem  (d_rem[g+1]),
            .o_dq   (d_dq[g+1]),
            .o_pay  (d_neg[g+1])
        );
    end

    // saturate, restore sign, narrow
    logic [2:0][COMP_W-1:0] res;
    logic [COMP_W-1:0]      qs;
    logic [COMP_W-1:0]      sg;
    logic                   r_out_valid;
    logic [95:0]            r_out_data;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qs = (d_dq[DW][k][DW-1:COMP_W-1] != '0) ? SAT_MAX : d_dq[DW][k][COMP_W-1:0];
            sg = d_neg[DW][k] ? (~qs + COMP_W'(1)) : qs;
            if (d_ctl[DW].zero) begin
                res[k] = '0;
            end else if (r_narrow) begin
                res[k] = {{(COMP_W-16){sg[15]}}, sg[15:0]};
            end else begin
                res[k] = sg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_ctl[DW].valid;
        end
        if (en) begin
            r_out_data <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
endmodule

// File: rtl/vnf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vnf_sqrt_cell
// One digit step of the bitwise floor square root, registered.
// ----------------------------------------------------------------------------
module vnf_sqrt_cell #(
    parameter int SHIFT = 30,
    parameter int PW    = 96
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  vnf_pkg::t_ctl               i_ctl,
    input  logic [vnf_pkg::COMP_W-1:0]  i_v,
    input  logic [vnf_pkg::COMP_W-1:0]  i_root,
    input  logic [PW-1:0]               i_pay,
    output vnf_pkg::t_ctl               o_ctl,
    output logic [vnf_pkg::COMP_W-1:0]  o_v,
    output logic [vnf_pkg::COMP_W-1:0]  o_root,
    output logic [PW-1:0]               o_pay
);
    import vnf_pkg::*;

    localparam logic [COMP_W-1:0] BIT = COMP_W'(1) << SHIFT;

    logic [COMP_W-1:0] trial;
    logic [COMP_W-1:0] n_v, n_root;
    t_ctl              r_ctl;
    logic [COMP_W-1:0] r_v, r_root;
    logic [PW-1:0]     r_pay;

    always_comb begin
        trial = i_root + BIT;
        if (i_v >= trial) begin
            n_v    = i_v - trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_v    = i_v;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_v    <= n_v;
            r_root <= n_root;
            r_pay  <= i_pay;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_v    = r_v;
    assign o_root = r_root;
    assign o_pay  = r_pay;
endmodule

// File: rtl/vnf_div_cell.sv
// ----------------------------------------------------------------------------
// vnf_div_cell
// One restoring division step for all three components, registered.
// ----------------------------------------------------------------------------
module vnf_div_cell #(
    parameter int DW = 44,
    parameter int PW = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  vnf_pkg::t_ctl                   i_ctl,
    input  logic [vnf_pkg::LEN_W-1:0]       i_len,
    input  logic [2:0][vnf_pkg::LEN_W-1:0]  i_rem,
    input  logic [2:0][DW-1:0]              i_dq,
    input  logic [PW-1:0]                   i_pay,
    output vnf_pkg::t_ctl                   o_ctl,
    output logic [vnf_pkg::LEN_W-1:0]       o_len,
    output logic [2:0][vnf_pkg::LEN_W-1:0]  o_rem,
    output logic [2:0][DW-1:0]              o_dq,
    output logic [PW-1:0]                   o_pay
);
    import vnf_pkg::*;

    logic [2:0][LEN_W:0]   trial;
    logic [2:0]            ge;
    logic [2:0][LEN_W-1:0] n_rem;
    logic [2:0][DW-1:0]    n_dq;
    t_ctl                  r_ctl;
    logic [LEN_W-1:0]      r_len;
    logic [2:0][LEN_W-1:0] r_rem;
    logic [2:0][DW-1:0]    r_dq;
    logic [PW-1:0]         r_pay;

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            trial[k] = {i_rem[k], i_dq[k][DW-1]};
            ge[k]    = trial[k] >= {1'b0, i_len};
            n_rem[k] = ge[k] ? LEN_W'(trial[k] - {1'b0, i_len}) : LEN_W'(trial[k]);
            n_dq[k]  = {i_dq[k][DW-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_len <= i_len;
            r_rem <= n_rem;
            r_dq  <= n_dq;
            r_pay <= i_pay;
        end
    end

    assign o_ctl = r_ctl;
    assign o_len = r_len;
    assign o_rem = r_rem;
    assign o_dq  = r_dq;
    assign o_pay = r_pay;
endmodule

// File: rtl/vnf_check.sv
// ----------------------------------------------------------------------------
// vnf_check
// Port-level checks of the vector normalizer.
// ----------------------------------------------------------------------------
module vnf_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output free");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:0] != 32'h8000_0000 &&
                           m_axis_tdata[63:32] != 32'h8000_0000 &&
                           m_axis_tdata[95:64] != 32'h8000_0000))
        else $error("result magnitude not saturated");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind vector_normalize_fixed_unit vnf_check u_vnf_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams three-component vectors into the fixed-point normalizer, predicts
// each normalized vector in-line, and compares results in order. Both stream
// sides idle at random; the output mode is switched between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 12;
    localparam int LATENCY = 21 + 32 + FRAC;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;

    logic [95:0] vec_queue[$];
    logic [95:0] norm_queue[$];
    bit          narrow_mode;
    int          errors;
    int          send_gap;
    int          recv_gap;
    bit          sending;
    int          n_queued;
    int          n_checked;

    vector_normalize_fixed_unit #(.FRAC_BITS(FRAC)) u_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] root_floor(logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] scale_comp(logic [31:0] raw, logic [31:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        logic [31:0] r;
        if (len == 0) return 0;
        mag = raw[31] ? {32'b0, -raw} : {32'b0, raw};
        q = (mag << FRAC) / {32'b0, len};
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        r = q[31:0];
        if (raw[31]) r = -r;
        if (narrow_mode) r = {{16{r[15]}}, r[15:0]};
        return r;
    endfunction

    function automatic logic [95:0] normalize_vec(logic [95:0] v);
        logic [31:0] sum;
        logic [31:0] len;
        sum = v[31:0] * v[31:0] + v[63:32] * v[63:32] + v[95:64] * v[95:64];
        len = sum[31] ? 32'd0 : root_floor(sum);
        return {scale_comp(v[95:64], len), scale_comp(v[63:32], len),
                scale_comp(v[31:0], len)};
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 255) - 128;
            2: return $urandom_range(0, 65535) - 32768;
            3: return $urandom_range(0, 46340) * ($urandom_range(0, 1) ? -1 : 1);
            4: return {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0, 12'($urandom)};
            default: return $urandom_range(0, 3000) - 1500;
        endcase
    endfunction

    // driver: take the next item from the queue after a random gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold
        end else begin
            if (s_axis_tvalid) norm_queue.push_back(normalize_vec(s_axis_tdata));
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (sending && vec_queue.size() > 0) begin
                s_axis_tdata <= vec_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_checked++;
                if (norm_queue.size() == 0) begin
                    $display("%t unexpected result %h", $realtime, m_axis_tdata);
                    errors++;
                end else begin
                    logic [95:0] exp_v;
                    exp_v = norm_queue.pop_front();
                    for (int k = 0; k < 3; k++)
                        if (exp_v[k*32 +: 32] !== m_axis_tdata[k*32 +: 32]) begin
                            $display("%t comp %0d expected %h actual %h", $realtime, k,
                                     exp_v[k*32 +: 32], m_axis_tdata[k*32 +: 32]);
                            errors++;
                        end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    // send the queued items, then hold until every result has been checked
    task automatic drain();
        n_queued += vec_queue.size();
        sending = 1'b1;
        wait (n_checked == n_queued);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_mode(bit m);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        narrow_mode = m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        sending = 1'b0;
        narrow_mode = 1'b0;
        errors = 0;
        recv_gap = 0;
        n_queued = 0;
        n_checked = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            set_mode(phase[0]);
            sending = 1'b0;
            // extremes, zero vector, wrapped sum, saturation
            vec_queue.push_back({32'd0, 32'd0, 32'd0});
            vec_queue.push_back({32'd0, 32'd0, 32'd1});
            vec_queue.push_back({32'd0, 32'd0, 32'hFFFF_FFFF});
            vec_queue.push_back({32'd0, 32'd0, 32'h8000_0000});
            vec_queue.push_back({32'd0, 32'h7FFF_FFFF, 32'd0});
            vec_queue.push_back({32'd46340, 32'd0, 32'd0});
            vec_queue.push_back({32'd46341, 32'd0, 32'd0});
            vec_queue.push_back({32'd3, 32'hFFFF_FFFC, 32'd0});
            vec_queue.push_back({32'd1, 32'd1, 32'd1});
            vec_queue.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
            vec_queue.push_back({32'd30000, 32'd30000, 32'd0});
            vec_queue.push_back({32'd1, 32'd0, 32'd40000});
            vec_queue.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555});
            for (int n = 0; n < 125; n++)
                vec_queue.push_back({rand_comp(), rand_comp(), rand_comp()});
            drain();
        end
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// File: sim.f
rtl/vnf_pkg.sv
rtl/vnf_sqrt_cell.sv
rtl/vnf_div_cell.sv
rtl/vector_normalize_fixed_unit.sv
rtl/vnf_check.sv
sim/tb.sv
